### hdl/pmlfq_pkg.sv
// pmlfq_pkg: shared codes and constants for the thread scheduler
// operation, status, thread-state and register-index codes; no dependencies
package pmlfq_pkg;

  localparam int LVL_W   = 2;
  localparam int STAMP_W = 16;

  localparam logic [5:0] PRIO_START = 6'd31;
  localparam logic [4:0] AGE_MAX    = 5'd31;
  localparam logic [3:0] CNT_MAX    = 4'd15;

  // thread states
  localparam logic [1:0] ST_BLOCKED = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  // operations
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_BLOCK   = 3'd2;
  localparam logic [2:0] OP_UNBLOCK = 3'd3;
  localparam logic [2:0] OP_YIELD   = 3'd4;
  localparam logic [2:0] OP_SETPRIO = 3'd5;
  localparam logic [2:0] OP_EXIT    = 3'd6;

  // result status
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_BAD     = 2'd2;
  localparam logic [1:0] STS_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_AGELIM = 3'd1;
  localparam logic [2:0] CFG_CAP    = 3'd2;
  localparam logic [2:0] CFG_RR     = 3'd3;
  localparam logic [2:0] CFG_SLICE0 = 3'd4;
  localparam logic [2:0] CFG_SLICE1 = 3'd5;
  localparam logic [2:0] CFG_SLICE2 = 3'd6;

endpackage

### hdl/priority_mlfq_scheduler_with_aging_top.sv
// A rejected op, an unused op or an unblock from interrupt context while a thread runs
// goes straight to the result; dispatching ops (create, block, unblock, yield, set
// priority, exit) scan every slot to pick the thread to run; a tick first ages the ready
// threads, each queue head in turn over the levels scanned, and dispatches again when it
// yields. One slot per cycle through one comparator.
// One item at a time; the result register lets the next item enter while it waits.
// Reset (rst, synchronous) empties the thread table at once: no clearing pass.
// depends on pmlfq_pkg
module priority_mlfq_scheduler_with_aging_top #(
  parameter int MAX_THREADS = 16,
  parameter int NUM_LEVELS  = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [3:0] thread_index,
  input  logic [5:0] priority_value,
  input  logic       from_interrupt,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] running_index,
  output logic       running_valid,
  output logic [3:0] created_index,
  output logic       switched,
  output logic [1:0] status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data
);

  localparam int SW = $clog2(MAX_THREADS);
  localparam logic [SW-1:0] LAST = SW'(MAX_THREADS - 1);
  localparam logic [pmlfq_pkg::LVL_W-1:0] TOP_LVL = pmlfq_pkg::LVL_W'(NUM_LEVELS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_TPROC = 4'd3;
  localparam logic [3:0] S_TEND  = 4'd4;
  localparam logic [3:0] S_ENQ   = 4'd5;
  localparam logic [3:0] S_DISP  = 4'd6;
  localparam logic [3:0] S_PRE   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] R_TICK = 2'd0;
  localparam logic [1:0] R_DISP = 2'd1;
  localparam logic [1:0] R_PRE  = 2'd2;

  // configuration
  logic       mode;
  logic [4:0] age_limit;
  logic [5:0] cap;
  logic [3:0] rr_slice;
  logic [3:0] slice0, slice1, slice2;

  // thread table
  logic [MAX_THREADS-1:0]         used;
  logic [1:0]                     st    [MAX_THREADS];
  logic [5:0]                     prio  [MAX_THREADS];
  logic [pmlfq_pkg::LVL_W-1:0]    lvl   [MAX_THREADS];
  logic [4:0]                     age   [MAX_THREADS];
  logic [3:0]                     slice [MAX_THREADS];
  logic [pmlfq_pkg::STAMP_W-1:0]  stamp [MAX_THREADS];

  // scheduler state
  logic [pmlfq_pkg::STAMP_W-1:0] counter;
  logic [SW-1:0] cur;
  logic          cv;
  logic [3:0]    stc;

  // sequencer and scan unit
  logic [3:0]    state;
  logic [1:0]    ret;
  logic [SW-1:0] scan_idx;
  logic [SW-1:0] best_idx;
  logic          best_found;
  logic [5:0]    best_prio;
  logic [pmlfq_pkg::LVL_W-1:0]   best_lvl;
  logic [pmlfq_pkg::STAMP_W-1:0] best_stamp;
  logic [MAX_THREADS-1:0] seen;
  logic          scan_any;
  logic [pmlfq_pkg::LVL_W-1:0] scan_lvl;

  // latched item and result
  logic [2:0] op_q;
  logic [3:0] idx_q;
  logic [5:0] pv_q;
  logic       intr_q;
  logic [SW-1:0] created_r;
  logic       sw_r;
  logic [1:0] status_r;
  logic       force_sw;

  function automatic logic [3:0] slice_for(input logic [pmlfq_pkg::LVL_W-1:0] l,
                                           input logic [3:0] a, input logic [3:0] b,
                                           input logic [3:0] c);
    logic [3:0] r;
    if (l == '0) r = a;
    else if (l == pmlfq_pkg::LVL_W'(1)) r = b;
    else r = c;
    return r;
  endfunction

  // single table read port
  logic [SW-1:0] ra;
  logic [SW-1:0] uidx;
  logic [1:0]    rd_st;
  logic [5:0]    rd_prio;
  logic [pmlfq_pkg::LVL_W-1:0]   rd_lvl;
  logic [4:0]    rd_age;
  logic [3:0]    rd_slice;
  logic [pmlfq_pkg::STAMP_W-1:0] rd_stamp;

  assign uidx = SW'(idx_q);

  always_comb begin
    case (state)
      S_SCAN:  ra = scan_idx;
      S_TPROC: ra = best_idx;
      S_START: ra = uidx;
      default: ra = cur;
    endcase
  end

  assign rd_st    = st[ra];
  assign rd_prio  = prio[ra];
  assign rd_lvl   = lvl[ra];
  assign rd_age   = age[ra];
  assign rd_slice = slice[ra];
  assign rd_stamp = stamp[ra];

  // first free slot
  logic [SW-1:0] free_idx;
  logic          full;
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SW'(i);
        full     = 1'b0;
      end
    end
  end

  logic idx_bad;
  assign idx_bad = (32'(idx_q) >= MAX_THREADS) || !used[uidx] ||
                   (rd_st != pmlfq_pkg::ST_BLOCKED);

  // decode of the latched op: status, forced switch and where the first scan returns
  logic [1:0] start_sts;
  logic [1:0] start_ret;
  logic       start_force;
  always_comb begin
    case (op_q)
      pmlfq_pkg::OP_CREATE:  start_sts = full ? pmlfq_pkg::STS_FULL : pmlfq_pkg::STS_OK;
      pmlfq_pkg::OP_BLOCK:   start_sts = cv ? pmlfq_pkg::STS_OK : pmlfq_pkg::STS_BAD;
      pmlfq_pkg::OP_EXIT:    start_sts = cv ? pmlfq_pkg::STS_OK : pmlfq_pkg::STS_BAD;
      pmlfq_pkg::OP_UNBLOCK: start_sts = idx_bad ? pmlfq_pkg::STS_BAD : pmlfq_pkg::STS_OK;
      pmlfq_pkg::OP_SETPRIO: start_sts = mode ? pmlfq_pkg::STS_IGNORED :
                                         (cv ? pmlfq_pkg::STS_OK : pmlfq_pkg::STS_BAD);
      default:               start_sts = pmlfq_pkg::STS_OK;
    endcase
  end

  always_comb begin
    case (op_q)
      pmlfq_pkg::OP_TICK:    start_ret = R_TICK;
      pmlfq_pkg::OP_CREATE:  start_ret = cv ? R_PRE : R_DISP;
      pmlfq_pkg::OP_UNBLOCK: start_ret = cv ? R_PRE : R_DISP;
      pmlfq_pkg::OP_SETPRIO: start_ret = R_PRE;
      default:               start_ret = R_DISP;
    endcase
  end

  assign start_force = ((op_q == pmlfq_pkg::OP_BLOCK) || (op_q == pmlfq_pkg::OP_EXIT)) && cv;

  // slot comparator: candidate at scan_idx against best so far
  logic [pmlfq_pkg::STAMP_W-1:0] wait_c, wait_b;
  logic older, prec, elig, take;
  assign wait_c = counter - rd_stamp;
  assign wait_b = counter - best_stamp;
  assign older  = wait_c > wait_b;
  assign prec   = mode ? ((rd_lvl != best_lvl) ? (rd_lvl < best_lvl) : older)
                       : ((rd_prio != best_prio) ? (rd_prio > best_prio) : older);
  assign elig   = used[scan_idx] && (rd_st == pmlfq_pkg::ST_READY) && !seen[scan_idx] &&
                  (scan_any || (rd_lvl == scan_lvl));
  assign take   = elig && (!best_found || prec);

  // aging of the picked slot
  logic [4:0] age_inc;
  logic       promote;
  assign age_inc = (rd_age == pmlfq_pkg::AGE_MAX) ? rd_age : rd_age + 5'd1;
  assign promote = (age_inc >= age_limit) && (mode || (rd_prio < cap));

  // end of tick for the running thread
  logic       expired;
  logic [pmlfq_pkg::LVL_W-1:0] nl;
  logic [3:0] stc_inc;
  logic       tend_yield;
  assign expired    = rd_slice <= 4'd1;
  assign nl         = (rd_lvl >= TOP_LVL) ? TOP_LVL : rd_lvl + pmlfq_pkg::LVL_W'(1);
  assign stc_inc    = (stc == pmlfq_pkg::CNT_MAX) ? stc : stc + 4'd1;
  assign tend_yield = !cv || (mode ? expired : (stc_inc >= rr_slice));

  // preemption test of queue head against running thread
  logic win;
  assign win = mode ? (best_lvl < rd_lvl) : (best_prio > rd_prio);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // control state, config and table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= R_DISP;
      cv         <= 1'b0;
      cur        <= '0;
      counter    <= '0;
      stc        <= '0;
      used       <= '0;
      for (int i = 0; i < MAX_THREADS; i++) st[i] <= pmlfq_pkg::ST_BLOCKED;
      out_valid  <= 1'b0;
      best_found <= 1'b0;
      seen       <= '0;
      scan_idx   <= '0;
      mode       <= 1'b0;
      age_limit  <= 5'd20;
      cap        <= 6'd31;
      rr_slice   <= 4'd4;
      slice0     <= 4'd2;
      slice1     <= 4'd4;
      slice2     <= 4'd8;
    end else begin
      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          pmlfq_pkg::CFG_MODE:   mode      <= cfg_data[0];
          pmlfq_pkg::CFG_AGELIM: age_limit <= cfg_data[4:0];
          pmlfq_pkg::CFG_CAP:    cap       <= cfg_data;
          pmlfq_pkg::CFG_RR:     rr_slice  <= cfg_data[3:0];
          pmlfq_pkg::CFG_SLICE0: slice0    <= cfg_data[3:0];
          pmlfq_pkg::CFG_SLICE1: slice1    <= cfg_data[3:0];
          pmlfq_pkg::CFG_SLICE2: slice2    <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= op;
            idx_q  <= thread_index;
            pv_q   <= priority_value;
            intr_q <= from_interrupt;
            state  <= S_START;
          end
        end

        // decode the op and start the first scan (a yield requeues first; an op with no dispatch finishes)
        S_START: begin
          sw_r       <= 1'b0;
          created_r  <= (op_q == pmlfq_pkg::OP_CREATE) ? free_idx : '0;
          status_r   <= start_sts;
          force_sw   <= start_force;
          seen       <= '0;
          scan_idx   <= '0;
          best_found <= 1'b0;
          scan_any   <= !((op_q == pmlfq_pkg::OP_TICK) && mode);
          scan_lvl   <= pmlfq_pkg::LVL_W'(1);
          ret        <= start_ret;
          case (op_q)
            pmlfq_pkg::OP_TICK: state <= S_SCAN;
            pmlfq_pkg::OP_CREATE: begin
              if (full) begin
                state <= S_DONE;
              end else begin
                used[free_idx] <= 1'b1;
                st[free_idx]   <= pmlfq_pkg::ST_READY;
                counter        <= counter + 16'd1;
                state          <= S_SCAN;
              end
            end
            pmlfq_pkg::OP_BLOCK: begin
              if (!cv) begin
                state <= S_DONE;
              end else begin
                st[cur] <= pmlfq_pkg::ST_BLOCKED;
                cv      <= 1'b0;
                state   <= S_SCAN;
              end
            end
            pmlfq_pkg::OP_UNBLOCK: begin
              if (idx_bad) begin
                state <= S_DONE;
              end else begin
                st[uidx] <= pmlfq_pkg::ST_READY;
                counter  <= counter + 16'd1;
                if (!cv || !intr_q) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            pmlfq_pkg::OP_YIELD: state <= S_ENQ;
            pmlfq_pkg::OP_SETPRIO: begin
              if (mode || !cv) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            pmlfq_pkg::OP_EXIT: begin
              if (!cv) begin
                state <= S_DONE;
              end else begin
                used[cur] <= 1'b0;
                st[cur]   <= pmlfq_pkg::ST_BLOCKED;
                cv        <= 1'b0;
                state     <= S_SCAN;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        // one slot per cycle through the comparator
        S_SCAN: begin
          if (take) begin
            best_found <= 1'b1;
            best_idx   <= scan_idx;
            best_prio  <= rd_prio;
            best_lvl   <= rd_lvl;
            best_stamp <= rd_stamp;
          end
          if (scan_idx == LAST) begin
            scan_idx <= '0;
            case (ret)
              R_TICK:  state <= S_TPROC;
              R_DISP:  state <= S_DISP;
              default: state <= S_PRE;
            endcase
          end else begin
            scan_idx <= scan_idx + SW'(1);
          end
        end

        // age the head found and look for the next; none left: next level in level mode, else end tick
        S_TPROC: begin
          best_found <= 1'b0;
          if (best_found) begin
            seen[best_idx] <= 1'b1;
            if (promote) counter <= counter + 16'd1;
            state <= S_SCAN;
          end else if (mode && (scan_lvl < TOP_LVL)) begin
            scan_lvl <= scan_lvl + pmlfq_pkg::LVL_W'(1);
            state    <= S_SCAN;
          end else begin
            state <= S_TEND;
          end
        end

        S_TEND: begin
          if (!mode) stc <= stc_inc;
          state <= tend_yield ? S_ENQ : S_DONE;
        end

        // requeue the running thread and dispatch over every slot
        S_ENQ: begin
          if (cv) begin
            st[cur] <= pmlfq_pkg::ST_READY;
            counter <= counter + 16'd1;
          end
          seen       <= '0;
          best_found <= 1'b0;
          scan_idx   <= '0;
          scan_any   <= 1'b1;
          ret        <= R_DISP;
          state      <= S_SCAN;
        end

        S_DISP: begin
          if (best_found) begin
            st[best_idx] <= pmlfq_pkg::ST_RUNNING;
            cur          <= best_idx;
          end else begin
            cur <= '0;
          end
          cv    <= best_found;
          stc   <= '0;
          sw_r  <= force_sw || (cv != best_found) || (best_found && (cur != best_idx));
          state <= S_DONE;
        end

        S_PRE: begin
          state <= (best_found && win) ? S_ENQ : S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            running_index <= cv ? 4'(cur) : 4'd0;
            running_valid <= cv;
            created_index <= 4'(created_r);
            switched      <= sw_r;
            status        <= status_r;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // table payload fields
  always_ff @(posedge clk) begin
    case (state)
      S_START: begin
        if (op_q == pmlfq_pkg::OP_CREATE && !full) begin
          prio[free_idx]  <= mode ? pmlfq_pkg::PRIO_START : pv_q;
          lvl[free_idx]   <= '0;
          slice[free_idx] <= slice0;
          age[free_idx]   <= '0;
          stamp[free_idx] <= counter;
        end else if (op_q == pmlfq_pkg::OP_UNBLOCK && !idx_bad) begin
          age[uidx]   <= '0;
          stamp[uidx] <= counter;
        end else if (op_q == pmlfq_pkg::OP_SETPRIO && !mode && cv) begin
          prio[cur] <= pv_q;
        end
      end
      S_TPROC: begin
        if (best_found) begin
          if (promote) begin
            age[best_idx]   <= '0;
            stamp[best_idx] <= counter;
            if (mode) lvl[best_idx] <= scan_lvl - pmlfq_pkg::LVL_W'(1);
            else      prio[best_idx] <= rd_prio + 6'd1;
          end else begin
            age[best_idx] <= age_inc;
          end
        end
      end
      S_TEND: begin
        if (mode && cv) begin
          if (expired) begin
            age[cur]   <= '0;
            lvl[cur]   <= nl;
            slice[cur] <= slice_for(nl, slice0, slice1, slice2);
          end else begin
            slice[cur] <= rd_slice - 4'd1;
          end
        end
      end
      S_ENQ: begin
        if (cv) begin
          age[cur]   <= '0;
          stamp[cur] <= counter;
        end
      end
      default: ;
    endcase
  end

  // checks
  logic [MAX_THREADS-1:0] run_vec;
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) run_vec[i] = (st[i] == pmlfq_pkg::ST_RUNNING);
  end

  a_cur_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cv) |-> (used[cur] && st[cur] == pmlfq_pkg::ST_RUNNING))
    else $error("running slot not marked running");

  a_one_running: assert property (@(posedge clk) disable iff (rst)
    $countones(run_vec) <= 1)
    else $error("more than one running thread");

  a_best_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && best_found) |-> (used[best_idx] && st[best_idx] == pmlfq_pkg::ST_READY))
    else $error("scan head not a ready thread");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished item not presented");

endmodule
